// ===== src/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define AEF_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define AEF_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/aef_pkg.sv =====
// Package: constants and result type for the alternating extremum finder.
`timescale 1ns / 1ps
`default_nettype none

package aef_pkg;

    localparam int MAX_SAMPLES_DEF = 256;
    localparam int SAMPLE_W        = 13;
    localparam int THR_W           = 12;
    localparam int IDX_OUT_W       = 8;
    localparam int CNT_OUT_W       = 9;
    localparam int S_TDATA_W       = 16;
    localparam int M_TDATA_W       = 24;
    localparam logic [THR_W-1:0] THRESHOLD_RESET = 12'd2;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] extremum_index;
        logic                 is_peak;
        logic [CNT_OUT_W-1:0] total_count;
        logic                 final_res;
    } result_t;

endpackage

`default_nettype wire

// ===== src/alternating_extremum_finder.sv =====
// Top level: alternating valley/peak detector with hysteresis threshold.
//
// Usage:
//   s_axis carries one signed 13-bit sample per transfer in tdata[12:0];
//   tlast marks the final sample of a sequence, which stands for a sentinel
//   peak at its own index (its value is ignored).
//   m_axis carries one result per transfer: extremum index, peak flag
//   (tuser), rounded-down-to-even count, tlast on the final result.
//   cfg_we/cfg_wdata write the 12-bit hysteresis threshold; write it only
//   while no sequence results are outstanding.
// Results: a result caused by a sample enters the result queue with the
//   sample transfer and is shown on m_axis once earlier results are taken.
//   A final sample may produce two results, presented one after the other.
// Throughput: one sample per cycle unless held off. Results go into a
//   4-entry result queue; s_axis_tready drops only while over two results wait.
// Reset: clears all tracking state and the queue, threshold returns to 2.
// Stall: when m_axis_tready is low, results collect in the queue and the
//   input is held off once the queue cannot take two more.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module alternating_extremum_finder #(
    parameter int MAX_SAMPLES = aef_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // config
    input  wire logic                         cfg_we,
    input  wire logic [aef_pkg::THR_W-1:0]    cfg_wdata,   // threshold
    // sample stream
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [aef_pkg::S_TDATA_W-1:0] s_axis_tdata, // [12:0] sample, [15:13] zero
    input  wire logic                         s_axis_tlast,  // last sample
    // result stream
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic [aef_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // [7:0] extremum_index,
                                                             // [16:8] total_count, [23:17] zero
    output logic                              m_axis_tuser,  // is_peak
    output logic                              m_axis_tlast   // final_res
);

    localparam int IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_SAMPLES - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

    // tracking state
    logic [aef_pkg::THR_W-1:0]           threshold_reg;
    logic                                seeking_peak_reg, seeking_peak_next;
    logic signed [aef_pkg::SAMPLE_W-1:0] tracked_value_reg, tracked_value_next;
    logic [IDX_W-1:0]                    tracked_index_reg, tracked_index_next;
    logic [IDX_W-1:0]                    sample_index_reg, sample_index_next;
    logic [CNT_W-1:0]                    count_reg, count_next;
    logic                                started_reg, started_next;

    // result queue
    aef_pkg::result_t                    fifo_mem [aef_pkg::FIFO_DEPTH];
    logic [aef_pkg::FIFO_PTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [aef_pkg::FIFO_CNT_W-1:0]      fifo_cnt_reg;

    logic                                in_xfer, out_xfer;
    logic signed [aef_pkg::SAMPLE_W-1:0] sample;
    logic signed [aef_pkg::SAMPLE_W:0]   swing;
    logic signed [aef_pkg::SAMPLE_W:0]   thr_ext;
    logic [CNT_W-1:0]                    count_inc1, count_inc2;
    logic [1:0]                          push_n;
    aef_pkg::result_t                    res0, res1;
    logic [IDX_W+aef_pkg::IDX_OUT_W-1:0] idx_wide_cur, idx_wide_trk;
    logic [CNT_W+aef_pkg::CNT_OUT_W-1:0] cnt_wide;
    aef_pkg::result_t                    head;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;
    assign sample   = s_axis_tdata[aef_pkg::SAMPLE_W-1:0];

    // room for two results keeps a final sample from overrunning the queue
    assign s_axis_tready = (fifo_cnt_reg <= aef_pkg::FIFO_CNT_W'(2));

    // 14-bit differences cover the full 13-bit range without overflow
    assign swing   = seeking_peak_reg
                   ? ((aef_pkg::SAMPLE_W+1)'(tracked_value_reg) - (aef_pkg::SAMPLE_W+1)'(sample))
                   : ((aef_pkg::SAMPLE_W+1)'(sample) - (aef_pkg::SAMPLE_W+1)'(tracked_value_reg));
    assign thr_ext = signed'({2'b00, threshold_reg});

    // saturating extremum counts: one bump for a pending valley, one for the peak
    assign count_inc1 = (count_reg < CNT_MAX) ? count_reg + CNT_W'(1) : count_reg;
    always_comb
    begin
        if (started_reg && !seeking_peak_reg)
        begin
            count_inc2 = (count_inc1 < CNT_MAX) ? count_inc1 + CNT_W'(1) : count_inc1;
        end
        else
        begin
            count_inc2 = count_inc1;
        end
    end

    // output fields take the low bits of the internal index and count
    assign idx_wide_cur = {{aef_pkg::IDX_OUT_W{1'b0}}, sample_index_reg};
    assign idx_wide_trk = {{aef_pkg::IDX_OUT_W{1'b0}}, tracked_index_reg};
    assign cnt_wide     = {{aef_pkg::CNT_OUT_W{1'b0}}, count_inc2};

    always_comb
    begin
        seeking_peak_next  = seeking_peak_reg;
        tracked_value_next = tracked_value_reg;
        tracked_index_next = tracked_index_reg;
        count_next         = count_reg;
        started_next       = started_reg;
        sample_index_next  = (sample_index_reg < IDX_MAX)
                           ? sample_index_reg + IDX_W'(1) : sample_index_reg;
        push_n             = 2'd0;

        // confirmed extreme of the current mode
        res0.extremum_index = idx_wide_trk[aef_pkg::IDX_OUT_W-1:0];
        res0.is_peak        = seeking_peak_reg;
        res0.total_count    = '0;
        res0.final_res      = 1'b0;

        // sentinel peak at the last sample
        res1.extremum_index = idx_wide_cur[aef_pkg::IDX_OUT_W-1:0];
        res1.is_peak        = 1'b1;
        res1.total_count    = {cnt_wide[aef_pkg::CNT_OUT_W-1:1], 1'b0};
        res1.final_res      = 1'b1;

        if (s_axis_tlast)
        begin
            if (started_reg && !seeking_peak_reg)
            begin
                push_n = 2'd2;
            end
            else
            begin
                push_n = 2'd1;
                res0   = res1;
            end
            seeking_peak_next  = 1'b0;
            tracked_value_next = '0;
            tracked_index_next = '0;
            sample_index_next  = '0;
            count_next         = '0;
            started_next       = 1'b0;
        end
        else if (!started_reg)
        begin
            started_next       = 1'b1;
            tracked_value_next = sample;
            tracked_index_next = sample_index_reg;
        end
        else if (swing >= thr_ext)
        begin
            push_n             = 2'd1;
            count_next         = count_inc1;
            seeking_peak_next  = !seeking_peak_reg;
            tracked_value_next = sample;
            tracked_index_next = sample_index_reg;
        end
        else if (seeking_peak_reg ? (sample > tracked_value_reg)
                                  : (sample < tracked_value_reg))
        begin
            tracked_value_next = sample;
            tracked_index_next = sample_index_reg;
        end
    end

    // control state, threshold and queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg     <= aef_pkg::THRESHOLD_RESET;
            seeking_peak_reg  <= 1'b0;
            tracked_value_reg <= '0;
            tracked_index_reg <= '0;
            sample_index_reg  <= '0;
            count_reg         <= '0;
            started_reg       <= 1'b0;
            wr_ptr_reg        <= '0;
            rd_ptr_reg        <= '0;
            fifo_cnt_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                threshold_reg <= cfg_wdata;
            end
            if (in_xfer)
            begin
                seeking_peak_reg  <= seeking_peak_next;
                tracked_value_reg <= tracked_value_next;
                tracked_index_reg <= tracked_index_next;
                sample_index_reg  <= sample_index_next;
                count_reg         <= count_next;
                started_reg       <= started_next;
                wr_ptr_reg        <= wr_ptr_reg + aef_pkg::FIFO_PTR_W'(push_n);
            end
            if (out_xfer)
            begin
                rd_ptr_reg <= rd_ptr_reg + aef_pkg::FIFO_PTR_W'(1);
            end
            fifo_cnt_reg <= fifo_cnt_reg
                          + (in_xfer ? aef_pkg::FIFO_CNT_W'(push_n) : '0)
                          - (out_xfer ? aef_pkg::FIFO_CNT_W'(1) : '0);
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (in_xfer && (push_n != 2'd0))
        begin
            fifo_mem[wr_ptr_reg] <= res0;
        end
        if (in_xfer && (push_n == 2'd2))
        begin
            fifo_mem[wr_ptr_reg + aef_pkg::FIFO_PTR_W'(1)] <= res1;
        end
    end

    assign head          = fifo_mem[rd_ptr_reg];
    assign m_axis_tvalid = (fifo_cnt_reg != '0);
    assign m_axis_tdata  = {{(aef_pkg::M_TDATA_W - aef_pkg::CNT_OUT_W - aef_pkg::IDX_OUT_W){1'b0}},
                            head.total_count, head.extremum_index};
    assign m_axis_tuser  = head.is_peak;
    assign m_axis_tlast  = head.final_res;

    // queue never holds more than its depth
    `AEF_ASSERT_ALWAYS(a_fifo_bound,
        fifo_cnt_reg <= aef_pkg::FIFO_CNT_W'(aef_pkg::FIFO_DEPTH),
        "result queue overflow")
    // sample index stays within the saturation limit
    `AEF_ASSERT_ALWAYS(a_idx_bound, sample_index_reg <= IDX_MAX,
        "sample index past saturation")
    // a last sample restarts the sequence
    `AEF_ASSERT_NEXT(a_seq_restart, in_xfer && s_axis_tlast,
        !started_reg && (sample_index_reg == '0) && (count_reg == '0),
        "sequence state not cleared after last sample")

endmodule

`default_nettype wire
